// ===== design/cfpk_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpk_pkg
// Shared types, constants and the CRC-8 step for the chunked frame packetizer.
// ----------------------------------------------------------------------------
package cfpk_pkg;

  localparam int LENGTH_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int MIN_FRAME_LEN    = 2;

  localparam logic [7:0] SYNC0           = 8'hAA;
  localparam logic [7:0] SYNC1           = 8'h55;
  localparam logic [7:0] MARK0           = 8'hFF;
  localparam logic [7:0] MARK1           = 8'hD8;
  localparam logic [7:0] CRC_POLY        = 8'h07;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd200;
  localparam logic [7:0] MIN_PAYLOAD     = 8'd2;

  // register index taken from paddr[2]
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_MARKER = 2'd2,
    ST_CHUNKS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_kind_t;

  // one queue entry; CMD_FRAME also opens a new frame in the back end
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic        last;
    logic [7:0]  data;
    logic [15:0] fid;
    logic [7:0]  count;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       big;
    logic [7:0] count;
  } div_res_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/cfpk_if.sv =====
// ----------------------------------------------------------------------------
// cfpk_if
// Valid/ready stream interfaces for the packetizer's input and result channels.
// ----------------------------------------------------------------------------
interface cfpk_in_if #(
  parameter int LENGTH_WIDTH = cfpk_pkg::LENGTH_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [LENGTH_WIDTH-1:0] frame_length;
  logic [7:0]              data_byte;

  modport source (output valid, opcode, frame_length, data_byte, input ready);
  modport sink   (input valid, opcode, frame_length, data_byte, output ready);
endinterface

interface cfpk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       byte_valid;
  logic       chunk_end;
  logic [1:0] status;
  logic       last;

  modport source (output valid, tx_byte, byte_valid, chunk_end, status, last, input ready);
  modport sink   (input valid, tx_byte, byte_valid, chunk_end, status, last, output ready);
endinterface

// ===== design/cfpk_queue.sv =====
// ----------------------------------------------------------------------------
// cfpk_queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cfpk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cfpk_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import cfpk_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/cfpk_div.sv =====
// ----------------------------------------------------------------------------
// cfpk_div
// Bit-serial restoring divider: chunk count = ceil(length / payload).
// ----------------------------------------------------------------------------
module cfpk_div #(
  parameter int LENGTH_WIDTH = cfpk_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [LENGTH_WIDTH-1:0]   len,
  input  logic [7:0]                payload,
  output cfpk_pkg::div_res_t        res
);
  import cfpk_pkg::*;

  localparam int DW = LENGTH_WIDTH + 1;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [7:0]    rem_r;
  logic [7:0]    q_r;
  logic          big_r;

  logic [8:0]    r_sh;
  logic          ge;

  assign r_sh = {rem_r, dvd_r[DW-1]};
  assign ge   = (r_sh >= {1'b0, payload});

  assign res.busy  = busy_r;
  assign res.big   = big_r;
  assign res.count = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient keeps its low byte; anything shifted past bit 7 marks > 255 chunks
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DW'(len) + DW'(payload) - DW'(1);
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? 8'(r_sh - {1'b0, payload}) : r_sh[7:0];
      q_r   <= {q_r[6:0], ge};
      big_r <= big_r | q_r[7];
    end
  end

endmodule

// ===== design/cfpk_front.sv =====
// ----------------------------------------------------------------------------
// cfpk_front
// Accepts input items, tracks frame state, checks the marker and queues
// commands for the back end.
// ----------------------------------------------------------------------------
module cfpk_front #(
  parameter int LENGTH_WIDTH = cfpk_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cfpk_in_if.sink                   in_ch,
  input  logic                      q_full,
  output logic                      q_push,
  output cfpk_pkg::cmd_t            q_cmd,
  output logic [LENGTH_WIDTH-1:0]   q_len,
  output logic                      div_start,
  output logic [LENGTH_WIDTH-1:0]   div_len,
  input  cfpk_pkg::div_res_t        div_res
);
  import cfpk_pkg::*;

  localparam int LW = LENGTH_WIDTH;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_DIV   = 3'b010,
    F_PUSH2 = 3'b100
  } front_state_t;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_STREAM = 2'd2
  } pos_t;

  front_state_t  state_r, state_nxt;
  pos_t          pos_r, pos_nxt;
  logic          active_r, active_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [7:0]    second_r, second_nxt;
  logic [15:0]   next_id_r, next_id_nxt;
  logic          accept;

  assign in_ch.ready = (state_r == F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  // chunk count is worked out once the marker pair is in, with the payload
  // that is current while the divider runs
  assign div_len     = left_r;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    active_nxt  = active_r;
    left_nxt    = left_r;
    held_nxt    = held_r;
    second_nxt  = second_r;
    next_id_nxt = next_id_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    q_len       = '0;
    div_start   = 1'b0;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_ch.opcode == OP_START) begin
            pos_nxt  = POS_FIRST;
            held_nxt = '0;
            if (in_ch.frame_length < LW'(MIN_FRAME_LEN)) begin
              q_push       = 1'b1;
              q_cmd.kind   = CMD_STATUS;
              q_cmd.status = ST_SHORT;
              q_cmd.last   = 1'b1;
              active_nxt   = 1'b0;
              left_nxt     = '0;
            end else begin
              active_nxt = 1'b1;
              left_nxt   = in_ch.frame_length;
            end
          end else if (active_r) begin
            unique case (pos_r)
              POS_FIRST: begin
                held_nxt = in_ch.data_byte;
                pos_nxt  = POS_SECOND;
              end
              POS_SECOND: begin
                if (held_r != MARK0 || in_ch.data_byte != MARK1) begin
                  q_push       = 1'b1;
                  q_cmd.kind   = CMD_STATUS;
                  q_cmd.status = ST_MARKER;
                  q_cmd.last   = 1'b1;
                  active_nxt   = 1'b0;
                  left_nxt     = '0;
                end else begin
                  second_nxt = in_ch.data_byte;
                  pos_nxt    = POS_STREAM;
                  div_start  = 1'b1;
                  state_nxt  = F_DIV;
                end
              end
              POS_STREAM: begin
                q_push     = 1'b1;
                q_cmd.kind = CMD_DATA;
                q_cmd.data = in_ch.data_byte;
                q_cmd.last = 1'b1;
                left_nxt   = left_r - LW'(1);
                if (left_r == LW'(1)) begin
                  active_nxt = 1'b0;
                end
              end
              default: begin
                pos_nxt = POS_FIRST;
              end
            endcase
          end
        end
      end
      F_DIV: begin
        if (!div_res.busy && !q_full) begin
          q_push = 1'b1;
          if (div_res.big) begin
            q_cmd.kind   = CMD_STATUS;
            q_cmd.status = ST_CHUNKS;
            q_cmd.last   = 1'b1;
            active_nxt   = 1'b0;
            left_nxt     = '0;
            state_nxt    = F_IDLE;
          end else begin
            // held marker byte opens the frame, the second byte follows
            q_cmd.kind  = CMD_FRAME;
            q_cmd.data  = held_r;
            q_cmd.fid   = next_id_r;
            q_cmd.count = div_res.count;
            q_len       = left_r;
            next_id_nxt = next_id_r + 16'd1;
            left_nxt    = left_r - LW'(2);
            if (left_r == LW'(2)) begin
              active_nxt = 1'b0;
            end
            state_nxt = F_PUSH2;
          end
        end
      end
      F_PUSH2: begin
        if (!q_full) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_DATA;
          q_cmd.data = second_r;
          q_cmd.last = 1'b1;
          state_nxt  = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      pos_r     <= POS_FIRST;
      active_r  <= 1'b0;
      left_r    <= '0;
      held_r    <= '0;
      next_id_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      active_r  <= active_nxt;
      left_r    <= left_nxt;
      held_r    <= held_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    second_r <= second_nxt;
  end

endmodule

// ===== design/cfpk_back.sv =====
// ----------------------------------------------------------------------------
// cfpk_back
// Expands queued commands into wire bytes: chunk header, data, CRC-8, or a
// status result. Holds the output register.
// ----------------------------------------------------------------------------
module cfpk_back #(
  parameter int LENGTH_WIDTH = cfpk_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  cfpk_pkg::cmd_t            q_cmd,
  input  logic [LENGTH_WIDTH-1:0]   q_len,
  output logic                      q_pop,
  input  logic [7:0]                payload,
  cfpk_out_if.source                out_ch
);
  import cfpk_pkg::*;

  localparam int LW = LENGTH_WIDTH;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_HDR  = 5'b00010,
    B_DATA = 5'b00100,
    B_CRC  = 5'b01000,
    B_STAT = 5'b10000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [7:0]    chunk_left_r, chunk_left_nxt;
  logic [7:0]    clen_r, clen_nxt;
  logic [2:0]    hdr_idx_r, hdr_idx_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    chunk_num_r, chunk_num_nxt;
  logic [7:0]    count_r, count_nxt;
  logic [15:0]   fid_r, fid_nxt;
  logic [7:0]    cur_byte_r, cur_byte_nxt;
  logic          cur_last_r, cur_last_nxt;
  status_t       cur_status_r, cur_status_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    tx_byte_r;
  logic          byte_valid_r, chunk_end_r, last_r;
  status_t       status_r;

  logic          load_ok;
  logic          emit;
  logic [7:0]    e_byte;
  logic          e_bv, e_cend, e_last;
  status_t       e_status;
  logic [7:0]    hdr_byte;

  assign load_ok = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_byte    = tx_byte_r;
  assign out_ch.byte_valid = byte_valid_r;
  assign out_ch.chunk_end  = chunk_end_r;
  assign out_ch.status     = status_r;
  assign out_ch.last       = last_r;

  always_comb begin
    unique case (hdr_idx_r)
      3'd0: hdr_byte = SYNC0;
      3'd1: hdr_byte = SYNC1;
      3'd2: hdr_byte = fid_r[7:0];
      3'd3: hdr_byte = fid_r[15:8];
      3'd4: hdr_byte = chunk_num_r;
      3'd5: hdr_byte = count_r;
      3'd6: hdr_byte = clen_r;
      3'd7: hdr_byte = 8'h00;   // chunk length never exceeds one byte
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    left_nxt       = left_r;
    chunk_left_nxt = chunk_left_r;
    clen_nxt       = clen_r;
    hdr_idx_nxt    = hdr_idx_r;
    crc_nxt        = crc_r;
    chunk_num_nxt  = chunk_num_r;
    count_nxt      = count_r;
    fid_nxt        = fid_r;
    cur_byte_nxt   = cur_byte_r;
    cur_last_nxt   = cur_last_r;
    cur_status_nxt = cur_status_r;
    q_pop          = 1'b0;
    emit           = 1'b0;
    e_byte         = '0;
    e_bv           = 1'b0;
    e_cend         = 1'b0;
    e_last         = 1'b0;
    e_status       = ST_OK;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          cur_byte_nxt   = q_cmd.data;
          cur_last_nxt   = q_cmd.last;
          cur_status_nxt = q_cmd.status;
          unique case (q_cmd.kind)
            CMD_STATUS: begin
              state_nxt = B_STAT;
            end
            CMD_FRAME: begin
              fid_nxt       = q_cmd.fid;
              count_nxt     = q_cmd.count;
              left_nxt      = q_len;
              chunk_num_nxt = '0;
              crc_nxt       = '0;
              hdr_idx_nxt   = '0;
              clen_nxt      = (q_len < LW'(payload)) ? q_len[7:0] : payload;
              state_nxt     = B_HDR;
            end
            CMD_DATA: begin
              if (chunk_left_r == '0) begin
                crc_nxt     = '0;
                hdr_idx_nxt = '0;
                clen_nxt    = (left_r < LW'(payload)) ? left_r[7:0] : payload;
                state_nxt   = B_HDR;
              end else begin
                state_nxt = B_DATA;
              end
            end
            default: begin
              state_nxt = B_IDLE;
            end
          endcase
        end
      end
      B_HDR: begin
        if (load_ok) begin
          emit        = 1'b1;
          e_byte      = hdr_byte;
          e_bv        = 1'b1;
          crc_nxt     = crc8_next(crc_r, hdr_byte);
          hdr_idx_nxt = hdr_idx_r + 3'd1;
          if (hdr_idx_r == 3'd7) begin
            chunk_left_nxt = clen_r;
            state_nxt      = B_DATA;
          end
        end
      end
      B_DATA: begin
        if (load_ok) begin
          emit           = 1'b1;
          e_byte         = cur_byte_r;
          e_bv           = 1'b1;
          crc_nxt        = crc8_next(crc_r, cur_byte_r);
          chunk_left_nxt = chunk_left_r - 8'd1;
          left_nxt       = left_r - LW'(1);
          if (chunk_left_r == 8'd1) begin
            state_nxt = B_CRC;
          end else begin
            e_last    = cur_last_r;
            state_nxt = B_IDLE;
          end
        end
      end
      B_CRC: begin
        if (load_ok) begin
          emit          = 1'b1;
          e_byte        = crc_r;
          e_bv          = 1'b1;
          e_cend        = 1'b1;
          e_last        = cur_last_r;
          chunk_num_nxt = chunk_num_r + 8'd1;
          state_nxt     = B_IDLE;
        end
      end
      B_STAT: begin
        if (load_ok) begin
          emit      = 1'b1;
          e_status  = cur_status_r;
          e_last    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_valid_r  <= 1'b0;
      left_r       <= '0;
      chunk_left_r <= '0;
      chunk_num_r  <= '0;
      crc_r        <= '0;
      hdr_idx_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      left_r       <= left_nxt;
      chunk_left_r <= chunk_left_nxt;
      chunk_num_r  <= chunk_num_nxt;
      crc_r        <= crc_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clen_r       <= clen_nxt;
    count_r      <= count_nxt;
    fid_r        <= fid_nxt;
    cur_byte_r   <= cur_byte_nxt;
    cur_last_r   <= cur_last_nxt;
    cur_status_r <= cur_status_nxt;
    if (emit) begin
      tx_byte_r    <= e_byte;
      byte_valid_r <= e_bv;
      chunk_end_r  <= e_cend;
      status_r     <= e_status;
      last_r       <= e_last;
    end
  end

endmodule

// ===== design/chunked_frame_packetizer_crc8.sv =====
// ----------------------------------------------------------------------------
// chunked_frame_packetizer_crc8
// Splits length-prefixed frames into CRC-8 protected chunks on a byte stream.
// ----------------------------------------------------------------------------
// Every item is taken when the two-entry command queue has room, but the byte
// that completes a good FF D8 marker holds off the next item while a
// bit-serial divider works out the chunk count, then while the frame command
// and the second marker byte are queued, and longer while the queue is full.
// The back end sets the sustained rate: each data byte is a queue pop and then
// the byte, the first byte of a chunk is preceded by eight header bytes, the
// last is followed by the CRC byte, and any byte waits while out_ch stalls.
// A rejected frame yields a single status result (byte_valid low) marked last.
// ----------------------------------------------------------------------------
module chunked_frame_packetizer_crc8 #(
  parameter int LENGTH_WIDTH = cfpk_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cfpk_in_if.sink                       in_ch,
  cfpk_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfpk_pkg::PADDR_W-1:0]  paddr,
  input  logic [cfpk_pkg::PDATA_W-1:0]  pwdata,
  output logic [cfpk_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import cfpk_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = CMD_W + LENGTH_WIDTH;

  logic [7:0]              max_payload_r;
  logic [7:0]              eff_payload;

  logic                    q_push, q_pop, q_full, q_empty;
  cmd_t                    f_cmd;
  logic [LENGTH_WIDTH-1:0] f_len;
  logic [QW-1:0]           q_wdata, q_rdata;
  cmd_t                    b_cmd;
  logic [LENGTH_WIDTH-1:0] b_len;

  logic                    div_start;
  logic [LENGTH_WIDTH-1:0] div_len;
  div_res_t                div_res;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? PDATA_W'(max_payload_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_PAYLOAD) begin
      max_payload_r <= pwdata[7:0];
    end
  end

  // payload below two behaves as two
  assign eff_payload = (max_payload_r < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_r;

  assign q_wdata = {f_len, f_cmd};
  assign b_cmd   = cmd_t'(q_rdata[CMD_W-1:0]);
  assign b_len   = q_rdata[QW-1 -: LENGTH_WIDTH];

  cfpk_div #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .len     (div_len),
    .payload (eff_payload),
    .res     (div_res)
  );

  cfpk_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd),
    .q_len     (f_len),
    .div_start (div_start),
    .div_len   (div_len),
    .div_res   (div_res)
  );

  cfpk_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  cfpk_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (b_cmd),
    .q_len   (b_len),
    .q_pop   (q_pop),
    .payload (eff_payload),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (!out_ch.byte_valid && out_ch.last))
    else $error("status result carries a wire byte or is not last");

  a_crc_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.chunk_end) |-> (out_ch.byte_valid && out_ch.status == ST_OK))
    else $error("chunk end without a wire byte");

endmodule
